// ===== rtl/fixed_block_pool_allocator_defines.svh =====
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on clk with reset held off
`define FBPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset held off
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

  // default pool capacity
  localparam int MAX_BLOCKS_DEF = 256;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int OFFSET_W   = 20;
  localparam int COUNT_W    = 9;
  localparam int BYTES_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_REJECT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'd1;

  // register reset values and limits
  localparam logic [COUNT_W-1:0] BLOCKS_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] BYTES_RESET  = 13'd8;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = 13'd4096;

  // effective configuration, already saturated
  typedef struct packed {
    logic [COUNT_W-1:0] pool_size;
    logic [BYTES_W-1:0] block_bytes;
  } fbpa_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/fbpa_if.sv =====
`default_nettype none

// request channel: action and block to return
interface fbpa_req_if;
  import fbpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  block_index;
  modport source (output valid, output action, output block_index, input ready);
  modport sink   (input valid, input action, input block_index, output ready);
endinterface

// result channel
interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_index;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COUNT_W-1:0]  free_count;
  modport source (output valid, output status, output granted_index,
                  output byte_offset, output free_count, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input byte_offset, input free_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbpa_cfg_regs.sv =====
`default_nettype none

module fbpa_cfg_regs #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fbpa_pkg::fbpa_cfg_t                  cfg
);
  import fbpa_pkg::*;

  localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam logic [COUNT_W-1:0] POOL_LIMIT = COUNT_W'(DEPTH);

  logic [COUNT_W-1:0] blocks_r;
  logic [BYTES_W-1:0] bytes_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r <= BLOCKS_RESET;
      bytes_r  <= BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BLOCKS_IN_USE: blocks_r <= cfg_wdata[COUNT_W-1:0];
        REG_BLOCK_BYTES:   bytes_r  <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp both settings into their usable range
  always_comb begin
    if (blocks_r == '0) cfg.pool_size = COUNT_W'(1);
    else if (blocks_r > POOL_LIMIT) cfg.pool_size = POOL_LIMIT;
    else cfg.pool_size = blocks_r;

    if (bytes_r == '0) cfg.block_bytes = BYTES_W'(1);
    else if (bytes_r > BYTES_MAX) cfg.block_bytes = BYTES_MAX;
    else cfg.block_bytes = bytes_r;
  end

endmodule

`default_nettype wire

// ===== rtl/fbpa_link_ram.sv =====
`default_nettype none

module fbpa_link_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [fbpa_pkg::INDEX_W-1:0]  wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [fbpa_pkg::INDEX_W-1:0]  rdata
);
  import fbpa_pkg::*;

  logic [INDEX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator.sv =====
// result: an accepted request moves to the execute state, and its result is registered when it commits
//   from there (held back until the result slot is free)
// sequencing: a new request is taken only in the idle state, after the previous one has committed;
//   the link memory at the list head is read on accept, before the head can move
// reset: synchronous, active low; all blocks free via the fresh-block counter,
//   link memory is left as is and needs no clearing pass
`default_nettype none

`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fbpa_req_if.sink                             in_req,
  fbpa_rsp_if.source                           out_rsp,
  input  wire logic                            cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COUNT_W-1:0] POOL_LIMIT = COUNT_W'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  fbpa_cfg_t cfg;

  logic                state_r;
  logic [ACTION_W-1:0] act_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [INDEX_W-1:0]  head_r, head_nxt;
  logic [COUNT_W-1:0]  len_r, len_nxt;
  logic [COUNT_W-1:0]  fresh_r, fresh_nxt;
  logic [COUNT_W-1:0]  free_r, free_nxt;
  logic [COUNT_W-1:0]  pool_r, pool_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic [INDEX_W-1:0]  grant_nxt;
  logic                link_we;
  logic [INDEX_W-1:0]  link_rdata;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_grant_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [COUNT_W-1:0]  out_free_r;

  logic                accept;
  logic                slot_free;
  logic                commit;
  logic [INDEX_W+BYTES_W-1:0] product;

  fbpa_cfg_regs #(.MAX_BLOCKS(MAX_BLOCKS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake and sequencing
  assign in_req.ready = rst_n && (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;
  assign commit       = (state_r == ST_EXEC) && slot_free;

  // link memory: head link read on accept, push written on commit
  fbpa_link_ram #(.DEPTH(DEPTH)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (head_r),
    .re    (accept),
    .raddr (head_r[AW-1:0]),
    .rdata (link_rdata)
  );

  // request decode and list update
  always_comb begin
    head_nxt   = head_r;
    len_nxt    = len_r;
    fresh_nxt  = fresh_r;
    free_nxt   = free_r;
    pool_nxt   = pool_r;
    status_nxt = STS_OK;
    grant_nxt  = '0;
    link_we    = 1'b0;
    case (act_r)
      ACT_INIT: begin
        pool_nxt  = cfg.pool_size;
        head_nxt  = '0;
        len_nxt   = '0;
        fresh_nxt = '0;
        free_nxt  = cfg.pool_size;
      end
      ACT_ALLOC: begin
        if (len_r != '0) begin
          // pop the most recently returned block
          grant_nxt = head_r;
          head_nxt  = link_rdata;
          len_nxt   = len_r - COUNT_W'(1);
          free_nxt  = free_r - COUNT_W'(1);
        end else if (fresh_r < pool_r) begin
          // hand out a never-used block
          grant_nxt = fresh_r[INDEX_W-1:0];
          fresh_nxt = fresh_r + COUNT_W'(1);
          free_nxt  = free_r - COUNT_W'(1);
        end else begin
          status_nxt = STS_EMPTY;
        end
      end
      ACT_FREE: begin
        if ({1'b0, idx_r} >= pool_r || free_r >= pool_r) begin
          status_nxt = STS_REJECT;
        end else begin
          link_we  = commit;
          head_nxt = idx_r;
          len_nxt  = len_r + COUNT_W'(1);
          free_nxt = free_r + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // byte offset of the granted block
  assign product = {{BYTES_W{1'b0}}, grant_nxt} * {{INDEX_W{1'b0}}, cfg.block_bytes};

  // control and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      len_r   <= '0;
      fresh_r <= '0;
      free_r  <= POOL_LIMIT;
      pool_r  <= POOL_LIMIT;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) begin
            state_r <= ST_IDLE;
            head_r  <= head_nxt;
            len_r   <= len_nxt;
            fresh_r <= fresh_nxt;
            free_r  <= free_nxt;
            pool_r  <= pool_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_req.action;
      idx_r <= in_req.block_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status_nxt;
      out_grant_r  <= grant_nxt;
      out_offset_r <= product[OFFSET_W-1:0];
      out_free_r   <= free_nxt;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_index = out_grant_r;
  assign out_rsp.byte_offset   = out_offset_r;
  assign out_rsp.free_count    = out_free_r;

  // checks
  `FBPA_ASSERT_NOW(a_free_in_pool, 1'b1, free_r <= pool_r, "free count above pool size")
  `FBPA_ASSERT_NOW(a_count_balance, 1'b1,
    {1'b0, free_r} + {1'b0, fresh_r} == {1'b0, len_r} + {1'b0, pool_r},
    "free count out of step with list length and fresh counter")
  `FBPA_ASSERT_NEXT(a_accept_exec, accept, state_r == ST_EXEC, "accepted request not executed")
  `FBPA_ASSERT_NOW(a_result_from_exec, $rose(out_valid_r), $past(state_r == ST_EXEC),
    "result appeared without an executing request")

endmodule

`default_nettype wire
